// ----- rtl/imu_omd_pkg.sv -----
// ----------------------------------------------------------------------------
// IMU orientation and motion detector - shared package
// Request and configuration types, mode and register codes, the sequence of
// products worked through the shared multiplier, and fixed compare limits.
// ----------------------------------------------------------------------------
package imu_omd_pkg;

  // Detector modes
  localparam logic [1:0] MODE_FACE_UP   = 2'd0;
  localparam logic [1:0] MODE_FACE_DOWN = 2'd1;
  localparam logic [1:0] MODE_FREE_FALL = 2'd2;
  localparam logic [1:0] MODE_MOVING    = 2'd3;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_HOLD      = 2'd2;

  localparam int unsigned ADDR_W = 4;

  // Reset values of the registers
  localparam logic [12:0] THRESHOLD_RST = 13'd3686;
  localparam logic [15:0] HOLD_RST      = 16'd100;

  // Stationary window: 0.88 g .. 1.12 g as 625 * |a|^2 against (22/25)^2, (28/25)^2
  localparam logic [41:0] STILL_LO = 42'd484 << 24;
  localparam logic [41:0] STILL_HI = 42'd784 << 24;
  // 15 deg/s = 240 units, squared
  localparam logic [31:0] RATE_STILL_MAX = 32'd57600;
  // Rate-delta scale: 50 deg/s per unit threshold, squared as 2500
  localparam logic [31:0] RATE_DELTA_K   = 32'd2500;
  localparam logic [31:0] STILL_K        = 32'd625;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic               accel_ok;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic               rate_ok;
    logic [31:0]        timestamp_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]  detector_mode;
    logic [12:0] threshold;
    logic [15:0] hold_ms;
  } cfg_t;

  // Products formed on the shared multiplier, in issue order
  typedef enum logic [3:0] {
    OP_TT, OP_AX, OP_AY, OP_AZ, OP_RX, OP_RY, OP_RZ,
    OP_DAX, OP_DAY, OP_DAZ, OP_DRX, OP_DRY, OP_DRZ,
    OP_TS, OP_S625, OP_T2500
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_RUN, BK_DRAIN, BK_DONE
  } back_state_t;

  // Step to the next product that the mode needs
  function automatic op_t next_op(input logic [1:0] mode, input op_t op);
    op_t nxt;
    nxt = op_t'(op + 4'd1);
    if (mode == MODE_MOVING && op == OP_TT) begin
      nxt = OP_DAX;
    end else if (mode == MODE_MOVING && op == OP_DRZ) begin
      nxt = OP_T2500;
    end else if (op == OP_RZ) begin
      nxt = OP_TS;
    end
    return nxt;
  endfunction

  // Final product of each mode's sequence
  function automatic op_t last_op(input logic [1:0] mode);
    op_t lst;
    unique case (mode) inside
      MODE_FACE_UP, MODE_FACE_DOWN: lst = OP_S625;
      MODE_FREE_FALL:               lst = OP_AZ;
      default:                      lst = OP_T2500;
    endcase
    return lst;
  endfunction

  // Magnitude of a 17-bit signed value known to lie within +/-65535
  function automatic logic [15:0] mag17(input logic signed [16:0] v);
    logic signed [16:0] neg;
    neg = -v;
    return v[16] ? neg[15:0] : v[15:0];
  endfunction

endpackage

// ----- rtl/imu_omd_front.sv -----
// ----------------------------------------------------------------------------
// IMU orientation and motion detector - front end
// Accepts samples and holds them in a two-entry queue that decouples the
// input handshake from the arithmetic back end.
// ----------------------------------------------------------------------------
module imu_omd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  imu_omd_pkg::item_t  in_item,
  output logic                q_valid,
  input  logic                q_ready,
  output imu_omd_pkg::item_t  q_item
);
  import imu_omd_pkg::*;

  item_t      q_mem [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;

  // Queue flags
  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Occupancy
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Store an incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_item;
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/imu_omd_back.sv -----
// ----------------------------------------------------------------------------
// IMU orientation and motion detector - back end
// Works one sample through a shared 32x32 multiplier, one product a cycle,
// then applies the selected detector, updates its state and publishes.
// ----------------------------------------------------------------------------
module imu_omd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  imu_omd_pkg::cfg_t   cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  imu_omd_pkg::item_t  q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_detected
);
  import imu_omd_pkg::*;

  back_state_t        state_r;
  back_state_t        state_nxt;
  op_t                step_r;
  item_t              item_r;
  logic               start;
  logic               issue;
  logic               finish;
  logic               out_free;

  // Shared multiplier
  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        mul_p;
  logic [15:0]        sq_op;
  logic [63:0]        prod_r;
  op_t                prod_tag_r;
  logic               prod_vld_r;

  // Accumulated terms
  logic [25:0]        t2_r;
  logic [31:0]        s_r;
  logic [31:0]        g_r;
  logic [30:0]        zsq_r;
  logic [33:0]        da_r;
  logic [33:0]        dr_r;
  logic [57:0]        ts_r;
  logic [41:0]        s625_r;
  logic [37:0]        t2500_r;

  // Detector state
  logic signed [15:0] pa_r [3];
  logic signed [15:0] pr_r [3];
  logic               pa_seen_r;
  logic               pr_seen_r;
  logic               shown_r;
  logic               fall_pend_r;
  logic [31:0]        fall_start_r;
  logic [31:0]        last_motion_r;

  // Output register
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_det_r;

  // Decision
  logic               still;
  logic               zpos;
  logic               fall_low;
  logic [31:0]        fall_el;
  logic [31:0]        quiet_el;
  logic               mv_a;
  logic               mv_r;
  logic               moving;
  logic               pub_en;
  logic               pub_val;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (q_valid) state_nxt = BK_RUN;
      BK_RUN:   if (step_r == last_op(cfg.detector_mode)) state_nxt = BK_DRAIN;
      BK_DRAIN: state_nxt = BK_DONE;
      BK_DONE:  if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_ready = 1'b0;
    issue   = 1'b0;
    finish  = 1'b0;
    unique case (state_r)
      BK_IDLE:  q_ready = 1'b1;
      BK_RUN:   issue   = 1'b1;
      BK_DRAIN: ;
      BK_DONE:  finish  = out_free;
      default:  ;
    endcase
  end

  assign start = q_ready && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Square operand for the axis and delta products
  always_comb begin
    case (step_r)
      OP_AX:   sq_op = mag17({item_r.accel_x[15], item_r.accel_x});
      OP_AY:   sq_op = mag17({item_r.accel_y[15], item_r.accel_y});
      OP_AZ:   sq_op = mag17({item_r.accel_z[15], item_r.accel_z});
      OP_RX:   sq_op = mag17({item_r.rate_x[15], item_r.rate_x});
      OP_RY:   sq_op = mag17({item_r.rate_y[15], item_r.rate_y});
      OP_RZ:   sq_op = mag17({item_r.rate_z[15], item_r.rate_z});
      OP_DAX:  sq_op = mag17({item_r.accel_x[15], item_r.accel_x} - {pa_r[0][15], pa_r[0]});
      OP_DAY:  sq_op = mag17({item_r.accel_y[15], item_r.accel_y} - {pa_r[1][15], pa_r[1]});
      OP_DAZ:  sq_op = mag17({item_r.accel_z[15], item_r.accel_z} - {pa_r[2][15], pa_r[2]});
      OP_DRX:  sq_op = mag17({item_r.rate_x[15], item_r.rate_x} - {pr_r[0][15], pr_r[0]});
      OP_DRY:  sq_op = mag17({item_r.rate_y[15], item_r.rate_y} - {pr_r[1][15], pr_r[1]});
      OP_DRZ:  sq_op = mag17({item_r.rate_z[15], item_r.rate_z} - {pr_r[2][15], pr_r[2]});
      default: sq_op = 16'd0;
    endcase
  end

  // Multiplier operand select
  always_comb begin
    unique case (step_r)
      OP_TT: begin
        mul_a = 32'(cfg.threshold);
        mul_b = 32'(cfg.threshold);
      end
      OP_TS: begin
        mul_a = s_r;
        mul_b = 32'(t2_r);
      end
      OP_S625: begin
        mul_a = s_r;
        mul_b = STILL_K;
      end
      OP_T2500: begin
        mul_a = 32'(t2_r);
        mul_b = RATE_DELTA_K;
      end
      default: begin
        mul_a = 32'(sq_op);
        mul_b = 32'(sq_op);
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Register each product, then fold it into its term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= OP_TT;
      prod_vld_r <= 1'b0;
      prod_tag_r <= OP_TT;
    end else begin
      prod_vld_r <= issue;
      if (start) begin
        step_r <= OP_TT;
      end else if (issue) begin
        step_r     <= next_op(cfg.detector_mode, step_r);
        prod_tag_r <= step_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= mul_p;
    end
    if (start) begin
      item_r <= q_item;
      s_r    <= 32'd0;
      g_r    <= 32'd0;
      da_r   <= 34'd0;
      dr_r   <= 34'd0;
    end else if (prod_vld_r) begin
      case (prod_tag_r) inside
        OP_TT:                  t2_r <= prod_r[25:0];
        OP_AX, OP_AY:           s_r  <= s_r + prod_r[31:0];
        OP_AZ: begin
          s_r   <= s_r + prod_r[31:0];
          zsq_r <= prod_r[30:0];
        end
        OP_RX, OP_RY, OP_RZ:    g_r  <= g_r + prod_r[31:0];
        OP_DAX, OP_DAY, OP_DAZ: da_r <= da_r + {2'd0, prod_r[31:0]};
        OP_DRX, OP_DRY, OP_DRZ: dr_r <= dr_r + {2'd0, prod_r[31:0]};
        OP_TS:                  ts_r    <= prod_r[57:0];
        OP_S625:                s625_r  <= prod_r[41:0];
        OP_T2500:               t2500_r <= prod_r[37:0];
        default: ;
      endcase
    end
  end

  // Apply the selected detector
  always_comb begin
    still = item_r.accel_ok && (s625_r >= STILL_LO) && (s625_r <= STILL_HI) &&
            !(item_r.rate_ok && (g_r > RATE_STILL_MAX));
    zpos = (cfg.detector_mode == MODE_FACE_UP) ? (item_r.accel_z > 16'sd0)
                                               : item_r.accel_z[15];
    fall_low = s_r < {6'd0, t2_r};
    fall_el  = item_r.timestamp_ms - fall_start_r;
    quiet_el = item_r.timestamp_ms - last_motion_r;
    mv_a     = item_r.accel_ok && pa_seen_r && (da_r > {8'd0, t2_r});
    mv_r     = item_r.rate_ok && pr_seen_r && ({dr_r, 16'd0} > {12'd0, t2500_r});
    moving   = mv_a || mv_r;
    pub_en   = 1'b0;
    pub_val  = 1'b0;
    unique case (cfg.detector_mode) inside
      MODE_FACE_UP, MODE_FACE_DOWN: begin
        pub_en  = still;
        pub_val = zpos && ({3'd0, zsq_r, 24'd0} > ts_r);
      end
      MODE_FREE_FALL: begin
        if (item_r.accel_ok) begin
          if (!fall_low) begin
            pub_en = 1'b1;
          end else if (fall_pend_r && (fall_el >= {16'd0, cfg.hold_ms})) begin
            pub_en  = 1'b1;
            pub_val = 1'b1;
          end
        end
      end
      default: begin
        if (item_r.accel_ok || item_r.rate_ok) begin
          if (moving) begin
            pub_en  = 1'b1;
            pub_val = 1'b1;
          end else if (shown_r && (quiet_el >= {16'd0, cfg.hold_ms})) begin
            pub_en = 1'b1;
          end
        end
      end
    endcase
  end

  // Update detector control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shown_r       <= 1'b0;
      fall_pend_r   <= 1'b0;
      fall_start_r  <= 32'd0;
      last_motion_r <= 32'd0;
      pa_seen_r     <= 1'b0;
      pr_seen_r     <= 1'b0;
    end else if (finish) begin
      if (pub_en) begin
        shown_r <= pub_val;
      end
      if (cfg.detector_mode == MODE_FREE_FALL) begin
        if (!item_r.accel_ok || !fall_low) begin
          fall_pend_r <= 1'b0;
        end else if (!fall_pend_r) begin
          fall_pend_r  <= 1'b1;
          fall_start_r <= item_r.timestamp_ms;
        end
      end
      if (cfg.detector_mode == MODE_MOVING) begin
        if (item_r.accel_ok) begin
          pa_seen_r <= 1'b1;
        end
        if (item_r.rate_ok) begin
          pr_seen_r <= 1'b1;
        end
        if (moving) begin
          last_motion_r <= item_r.timestamp_ms;
        end
      end
    end
  end

  // Hold previous samples for the delta test
  always_ff @(posedge clk) begin
    if (finish && cfg.detector_mode == MODE_MOVING) begin
      if (item_r.accel_ok) begin
        pa_r[0] <= item_r.accel_x;
        pa_r[1] <= item_r.accel_y;
        pa_r[2] <= item_r.accel_z;
      end
      if (item_r.rate_ok) begin
        pr_r[0] <= item_r.rate_x;
        pr_r[1] <= item_r.rate_y;
        pr_r[2] <= item_r.rate_z;
      end
    end
  end

  // Output register: drop on take, load on publish
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (finish && pub_en) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && pub_en) begin
      out_det_r <= pub_val;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_detected = out_det_r;

endmodule

// ----- rtl/imu_orientation_motion_detector.sv -----
// ----------------------------------------------------------------------------
// IMU orientation and motion detector - top level
// A request waits in the front-end queue; the back end then forms the products
// that its mode needs and may publish a result once the output register is free.
// The back end works one request at a time, the shared multiplier forming one
// product a cycle; two requests may queue in front.
// Synchronous active-low reset clears control state and loads register resets.
// ----------------------------------------------------------------------------
module imu_orientation_motion_detector (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [15:0]              in_accel_x,
  input  logic signed [15:0]              in_accel_y,
  input  logic signed [15:0]              in_accel_z,
  input  logic                            in_accel_ok,
  input  logic signed [15:0]              in_rate_x,
  input  logic signed [15:0]              in_rate_y,
  input  logic signed [15:0]              in_rate_z,
  input  logic                            in_rate_ok,
  input  logic [31:0]                     in_timestamp_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_detected,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [imu_omd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import imu_omd_pkg::*;

  cfg_t       cfg_r;
  item_t      in_item;
  item_t      q_item;
  logic       q_valid;
  logic       q_ready;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detector_mode <= MODE_FACE_UP;
      cfg_r.threshold     <= THRESHOLD_RST;
      cfg_r.hold_ms       <= HOLD_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:      cfg_r.detector_mode <= pwdata[1:0];
        REG_THRESHOLD: cfg_r.threshold     <= pwdata[12:0];
        REG_HOLD:      cfg_r.hold_ms       <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (reg_idx)
      REG_MODE:      prdata = {30'd0, cfg_r.detector_mode};
      REG_THRESHOLD: prdata = {19'd0, cfg_r.threshold};
      REG_HOLD:      prdata = {16'd0, cfg_r.hold_ms};
      default:       prdata = 32'd0;
    endcase
  end

  // Gather the request fields
  always_comb begin
    in_item.accel_x      = in_accel_x;
    in_item.accel_y      = in_accel_y;
    in_item.accel_z      = in_accel_z;
    in_item.accel_ok     = in_accel_ok;
    in_item.rate_x       = in_rate_x;
    in_item.rate_y       = in_rate_y;
    in_item.rate_z       = in_rate_z;
    in_item.rate_ok      = in_rate_ok;
    in_item.timestamp_ms = in_timestamp_ms;
  end

  imu_omd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  imu_omd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_detected (out_detected)
  );

endmodule

// ----- rtl/imu_omd_checker.sv -----
// ----------------------------------------------------------------------------
// IMU orientation and motion detector - port checker
// Watches the top-level ports for reset behaviour and result hand-off.
// ----------------------------------------------------------------------------
module imu_omd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_detected,
  input logic pready
);

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_detected))
    else $error("result dropped or changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Reset empties the request queue
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("not ready for requests after reset");

  // Configuration port never stalls
  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("configuration port stalled");

endmodule

bind imu_orientation_motion_detector imu_omd_checker u_imu_omd_checker (.*);
